// File: hdl/wmrb_pkg.sv
package wmrb_pkg;

  typedef struct packed {
    logic [31:0] msg_time;
    logic [1:0]  msg_source;
    logic [15:0] msg_handle;
  } msg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_time;
    logic [1:0]  out_source;
    logic [15:0] out_handle;
    logic        last;
  } res_t;

  // one stored message held by a cell
  typedef struct packed {
    logic        valid;
    logic [31:0] tstamp;
    logic [1:0]  source;
    logic [15:0] handle;
  } entry_t;

  typedef enum logic [1:0] {
    CellHold,
    CellInsert,
    CellUpdate,
    CellPop
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    msg_t     item;
  } cell_ctrl_t;

  localparam logic [1:0] StatusReleased = 2'd0;
  localparam logic [1:0] StatusLate     = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

endpackage

// File: hdl/wmrb_cell.sv
// One slot of the sorted chain. Entries stay packed toward cell 0, oldest first.
module wmrb_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wmrb_pkg::cell_ctrl_t ctrl_i,
  input  wmrb_pkg::entry_t    left_i,     // neighbor toward the head
  input  logic                left_gt_i,  // neighbor is past the insert point
  input  wmrb_pkg::entry_t    right_i,    // neighbor toward the tail
  output wmrb_pkg::entry_t    ent_o,
  output logic                gt_o,
  output logic                eq_o
);

  logic             valid_q, valid_d;
  logic [31:0]      tstamp_q, tstamp_d;
  logic [1:0]       source_q, source_d;
  logic [15:0]      handle_q, handle_d;

  assign gt_o = !valid_q || (tstamp_q > ctrl_i.item.msg_time);
  assign eq_o = valid_q && (tstamp_q == ctrl_i.item.msg_time);

  assign ent_o = '{valid: valid_q, tstamp: tstamp_q, source: source_q, handle: handle_q};

  always_comb begin
    valid_d  = valid_q;
    tstamp_d = tstamp_q;
    source_d = source_q;
    handle_d = handle_q;
    unique case (ctrl_i.op)
      wmrb_pkg::CellInsert: begin
        if (left_gt_i) begin
          valid_d  = left_i.valid;
          tstamp_d = left_i.tstamp;
          source_d = left_i.source;
          handle_d = left_i.handle;
        end else if (gt_o) begin
          valid_d  = 1'b1;
          tstamp_d = ctrl_i.item.msg_time;
          source_d = ctrl_i.item.msg_source;
          handle_d = ctrl_i.item.msg_handle;
        end
      end
      wmrb_pkg::CellUpdate: begin
        if (eq_o) begin
          source_d = ctrl_i.item.msg_source;
          handle_d = ctrl_i.item.msg_handle;
        end
      end
      wmrb_pkg::CellPop: begin
        valid_d  = right_i.valid;
        tstamp_d = right_i.tstamp;
        source_d = right_i.source;
        handle_d = right_i.handle;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tstamp_q <= tstamp_d;
    source_q <= source_d;
    handle_q <= handle_d;
  end

endmodule

// File: hdl/watermark_reorder_buffer.sv
// Channel  | handshake             | payload         | notes
// ---------+-----------------------+-----------------+-------------------------------
// input    | start / busy          | msg_i (msg_t)   | transfer at start && !busy
// result   | res_valid_o strobe    | res_o (res_t)   | one cycle, receiver cannot stall
// config   | psel/penable/pwrite   | pwdata / prdata | safe_delay at 0x0, pready tied 1
//
// An accepted message passes through the insert step (match, sorted insert,
// late or full check); busy stays high until idle again. When the watermark advances,
// the drain step follows: one released message per cycle popped off cell 0, or
// a single empty pass if nothing is due.
// Reset clears all valid bits, head and safe times and safe_delay at once.
// Results cannot be held off; busy is the only back-pressure, toward the sender.
module watermark_reorder_buffer #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // message input
  input  logic              start,
  output logic              busy,
  input  wmrb_pkg::msg_t    msg_i,
  // result output
  output logic              res_valid_o,
  output wmrb_pkg::res_t    res_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    StIdle,
    StInsert,
    StDrain
  } state_e;

  state_e               state_q;
  wmrb_pkg::msg_t       item_q;
  logic [31:0]          head_q;
  logic [31:0]          safe_q;
  logic [31:0]          delay_q;
  logic                 res_valid_q;
  wmrb_pkg::res_t       res_q;

  wmrb_pkg::cell_ctrl_t ctrl;
  wmrb_pkg::entry_t     ent   [DEPTH];
  logic                 gt    [DEPTH];
  logic                 eq    [DEPTH];

  logic                 any_match;
  logic                 full;
  logic                 late;
  logic [31:0]          mark;
  logic                 advance;
  logic                 head_due;
  logic                 next_due;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? delay_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= 32'd0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      delay_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 holds the oldest stored message
  // ---------------------------------------------------------------------------
  always_comb begin
    any_match = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      any_match = any_match | eq[i];
    end
  end

  assign full     = ent[DEPTH-1].valid;
  assign late     = item_q.msg_time < head_q;
  assign mark     = item_q.msg_time - delay_q;
  assign advance  = (item_q.msg_time > delay_q) && (mark > safe_q);
  assign head_due = ent[0].valid && (ent[0].tstamp <= safe_q);
  assign next_due = ent[1].valid && (ent[1].tstamp <= safe_q);

  always_comb begin
    ctrl.item = item_q;
    ctrl.op   = wmrb_pkg::CellHold;
    unique case (state_q)
      StInsert: begin
        if (late) begin
          ctrl.op = wmrb_pkg::CellHold;
        end else if (any_match) begin
          ctrl.op = wmrb_pkg::CellUpdate;
        end else if (!full) begin
          ctrl.op = wmrb_pkg::CellInsert;
        end
      end
      StDrain: begin
        if (head_due) begin
          ctrl.op = wmrb_pkg::CellPop;
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    wmrb_pkg::entry_t left_ent;
    wmrb_pkg::entry_t right_ent;
    logic             left_gt;

    if (g == 0) begin : g_first
      assign left_ent = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[g-1];
      assign left_gt  = gt[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[g+1];
    end

    wmrb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_ent),
      .left_gt_i (left_gt),
      .right_i   (right_ent),
      .ent_o     (ent[g]),
      .gt_o      (gt[g]),
      .eq_o      (eq[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  assign busy        = (state_q != StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= msg_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= 32'd0;
      safe_q      <= 32'd0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= StInsert;
          end
        end
        StInsert: begin
          if (late || (full && !any_match)) begin
            // rejected: echo the message back with its status
            res_valid_q      <= 1'b1;
            res_q.status     <= late ? wmrb_pkg::StatusLate : wmrb_pkg::StatusFull;
            res_q.out_time   <= item_q.msg_time;
            res_q.out_source <= item_q.msg_source;
            res_q.out_handle <= item_q.msg_handle;
            res_q.last       <= 1'b1;
            state_q          <= StIdle;
          end else if (advance) begin
            safe_q  <= mark;
            state_q <= StDrain;
          end else begin
            state_q <= StIdle;
          end
        end
        StDrain: begin
          if (head_due) begin
            res_valid_q      <= 1'b1;
            res_q.status     <= wmrb_pkg::StatusReleased;
            res_q.out_time   <= ent[0].tstamp;
            res_q.out_source <= ent[0].source;
            res_q.out_handle <= ent[0].handle;
            res_q.last       <= !next_due;
            head_q           <= ent[0].tstamp;
            if (!next_due) begin
              state_q <= StIdle;
            end
          end else begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // the first two cells stay sorted and packed toward the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent[1].valid |-> (ent[0].valid && (ent[0].tstamp < ent[1].tstamp)))
    else $error("cell chain out of order");

  // releases only come out of the drain step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == wmrb_pkg::StatusReleased)) |->
      $past(state_q == StDrain))
    else $error("release outside drain");

  // a release's time is taken over as the head time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == wmrb_pkg::StatusReleased)) |->
      (res_o.out_time == head_q))
    else $error("head time not following release");

  // an accepted message is always in the insert step next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == StInsert))
    else $error("accepted message lost");
`endif

endmodule
